[src/dpf_pkg.sv]
// Package: shared types and codes of the deduplicating packet buffer.
`default_nettype none
package dpf_pkg;

  localparam int DEPTH_DEF = 16;

  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_FORWARD = 2'd1;
  localparam logic [1:0] ACT_COUNT   = 2'd2;

  localparam logic       REG_MEM_LIMIT = 1'b0;
  localparam logic [4:0] MEM_LIMIT_RST = 5'd16;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] source;
    logic [15:0] destination;
    logic [31:0] timestamp;
    logic [31:0] start_time;
    logic [31:0] end_time;
  } in_req_t;

  typedef struct packed {
    logic        added;
    logic        packet_valid;
    logic [15:0] out_source;
    logic [15:0] out_destination;
    logic [31:0] out_timestamp;
    logic [4:0]  match_count;
  } out_res_t;

  typedef struct packed {
    logic [15:0] source;
    logic [15:0] destination;
    logic [31:0] timestamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clear;
    logic data_vld;
  } scan_ctl_t;

endpackage
`default_nettype wire

[src/dpf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dpf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[src/dpf_scan.sv]
// Compare unit: walks read data against the request, duplicate flag and match count.
`default_nettype none
module dpf_scan #(
  parameter int CNT_W = 5
) (
  input  wire logic               clk,
  input  wire dpf_pkg::scan_ctl_t ctl,
  input  wire dpf_pkg::in_req_t   req,
  input  wire dpf_pkg::entry_t    rd_data,
  output logic                    dup,
  output logic      [CNT_W-1:0]   count,
  output dpf_pkg::entry_t         first
);

  logic             dup_r, dup_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             first_pend_r, first_pend_nxt;
  dpf_pkg::entry_t  first_r, first_nxt;
  logic             same, in_range;

  always_comb begin
    same = (rd_data.source == req.source) && (rd_data.destination == req.destination)
        && (rd_data.timestamp == req.timestamp);
    in_range = (rd_data.destination == req.destination)
        && (rd_data.timestamp >= req.start_time) && (rd_data.timestamp <= req.end_time);
    dup_nxt        = dup_r;
    count_nxt      = count_r;
    first_pend_nxt = first_pend_r;
    first_nxt      = first_r;
    if (ctl.clear) begin
      dup_nxt        = 1'b0;
      count_nxt      = '0;
      first_pend_nxt = 1'b1;
    end else if (ctl.data_vld) begin
      dup_nxt = dup_r | same;
      if (in_range) begin
        count_nxt = count_r + CNT_W'(1);
      end
      if (first_pend_r) begin
        first_nxt      = rd_data;
        first_pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dup_r        <= dup_nxt;
    count_r      <= count_nxt;
    first_pend_r <= first_pend_nxt;
    first_r      <= first_nxt;
  end

  assign dup   = dup_r;
  assign count = count_r;
  assign first = first_r;

endmodule
`default_nettype wire

[src/dedup_packet_fifo_with_range_count.sv]
// Top level: packet buffer with duplicate filter, forward and range count.
//
// A request is taken when start is high and busy is low; busy stays high
// until its result is on out_res. Each request gives exactly one result,
// on out_res for one cycle with out_valid high; the receiver cannot stall.
// Actions: add (refused when an identical entry is held, evicts the oldest
// when the configured limit is reached), forward (pops the oldest entry),
// count (entries with the destination and a timestamp inside the range).
// Entries sit in one RAM with registered read data; add and count walk
// every held entry one read per cycle, forward reads the head entry only.
// A request runs through the states SCAN (the reads), WAIT and DONE, or
// straight to DONE when nothing is read. busy drops in the
// cycle out_valid is high, so the next request can be taken at the edge
// that takes the result; no request is taken before the last one is done.
// memory_limit is written through the cfg_ APB port at address 0; the user
// must write it only while idle, which the block does not enforce; 0 acts
// as 1, values above DEPTH act as DEPTH.
// Reset empties the buffer and sets memory_limit to 16; no clearing pass.
`default_nettype none
module dedup_packet_fifo_with_range_count #(
  parameter int DEPTH = dpf_pkg::DEPTH_DEF,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire dpf_pkg::in_req_t  in_req,
  output logic                   out_valid,
  output dpf_pkg::out_res_t      out_res,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [2:0]        cfg_paddr,
  input  wire logic [31:0]       cfg_pwdata,
  output logic      [31:0]       cfg_prdata,
  output logic                   cfg_pready
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  state_t             state_r, state_nxt;
  dpf_pkg::in_req_t   req_r, req_nxt;
  logic [IDX_W-1:0]   head_r, head_nxt;
  logic [IDX_W-1:0]   tail_r, tail_nxt;
  logic [IDX_W-1:0]   ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [CNT_W-1:0]   remain_r, remain_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [4:0]         limit_r, limit_nxt;
  logic               out_valid_r, out_valid_nxt;
  dpf_pkg::out_res_t  out_res_r, out_res_nxt;

  logic               accept, cfg_wr;
  logic [31:0]        lim32;
  logic [CNT_W-1:0]   eff_lim;
  logic [CNT_W-1:0]   scan_n;
  logic [31:0]        cnt32;
  logic               ram_we;
  dpf_pkg::entry_t    ram_wdata, ram_rdata, first;
  logic               dup;
  logic [CNT_W-1:0]   count;
  dpf_pkg::scan_ctl_t scan_ctl;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == {dpf_pkg::REG_MEM_LIMIT, 2'b00}) ?
                      {27'd0, limit_r} : 32'd0;

  always_comb begin
    lim32 = {27'd0, limit_r};
    if (lim32 == 32'd0) begin
      lim32 = 32'd1;
    end
    if (lim32 > 32'(DEPTH)) begin
      lim32 = 32'(DEPTH);
    end
    eff_lim = lim32[CNT_W-1:0];
  end

  always_comb begin
    unique case (in_req.action)
      dpf_pkg::ACT_ADD, dpf_pkg::ACT_COUNT: scan_n = held_r;
      dpf_pkg::ACT_FORWARD: scan_n = (held_r != '0) ? CNT_W'(1) : '0;
      default: scan_n = '0;
    endcase
  end

  assign scan_ctl.clear    = accept;
  assign scan_ctl.data_vld = rd_vld_r;

  assign ram_wdata.source      = req_r.source;
  assign ram_wdata.destination = req_r.destination;
  assign ram_wdata.timestamp   = req_r.timestamp;
  assign ram_we = (state_r == ST_DONE) && (req_r.action == dpf_pkg::ACT_ADD) && !dup;
  assign cnt32  = 32'(count);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    ptr_nxt       = ptr_r;
    held_nxt      = held_r;
    remain_nxt    = remain_r;
    rd_vld_nxt    = 1'b0;
    limit_nxt     = limit_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = '0;
    if (cfg_wr && (cfg_paddr == {dpf_pkg::REG_MEM_LIMIT, 2'b00})) begin
      limit_nxt = cfg_pwdata[4:0];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          req_nxt    = in_req;
          ptr_nxt    = head_r;
          remain_nxt = scan_n;
          state_nxt  = (scan_n == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        ptr_nxt    = (ptr_r == LAST_IDX) ? '0 : ptr_r + IDX_W'(1);
        remain_nxt = remain_r - CNT_W'(1);
        if (remain_r == CNT_W'(1)) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        unique case (req_r.action)
          dpf_pkg::ACT_ADD: begin
            if (!dup) begin
              out_res_nxt.added = 1'b1;
              tail_nxt = (tail_r == LAST_IDX) ? '0 : tail_r + IDX_W'(1);
              if (held_r >= eff_lim) begin
                head_nxt = (head_r == LAST_IDX) ? '0 : head_r + IDX_W'(1);
              end else begin
                held_nxt = held_r + CNT_W'(1);
              end
            end
          end
          dpf_pkg::ACT_FORWARD: begin
            if (held_r != '0) begin
              out_res_nxt.packet_valid    = 1'b1;
              out_res_nxt.out_source      = first.source;
              out_res_nxt.out_destination = first.destination;
              out_res_nxt.out_timestamp   = first.timestamp;
              head_nxt = (head_r == LAST_IDX) ? '0 : head_r + IDX_W'(1);
              held_nxt = held_r - CNT_W'(1);
            end
          end
          dpf_pkg::ACT_COUNT: begin
            out_res_nxt.match_count = cnt32[4:0];
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      held_r      <= '0;
      rd_vld_r    <= 1'b0;
      limit_r     <= dpf_pkg::MEM_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      held_r      <= held_nxt;
      rd_vld_r    <= rd_vld_nxt;
      limit_r     <= limit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r     <= req_nxt;
    ptr_r     <= ptr_nxt;
    remain_r  <= remain_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  dpf_ram #(
    .WIDTH (dpf_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_r),
    .wdata (ram_wdata),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  dpf_scan #(
    .CNT_W (CNT_W)
  ) u_scan (
    .clk     (clk),
    .ctl     (scan_ctl),
    .req     (req_r),
    .rd_data (ram_rdata),
    .dup     (dup),
    .count   (count),
    .first   (first)
  );

endmodule
`default_nettype wire
